@@ hw/rtl/infix_expression_evaluator_macros.svh @@
// Assertion macros shared by the evaluator RTL.
`ifndef INFIX_EXPRESSION_EVALUATOR_MACROS_SVH
`define INFIX_EXPRESSION_EVALUATOR_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define IEE_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);
// Implication whose consequent is checked in the next cycle.
`define IEE_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ hw/rtl/iee_pkg.sv @@
// ----------------------------------------------------------------------------
// iee_pkg
// Shared constants and types of the infix expression evaluator.
// ----------------------------------------------------------------------------
`default_nettype none
package iee_pkg;
    localparam int STACK_DEPTH_DEFAULT = 16;
    localparam int FRAC_BITS_DEFAULT   = 16;
    localparam int ACC_W               = 40;
    localparam int MAX_FRAC_DIGITS     = 8;

    localparam logic [2:0] OPC_ADD  = 3'd0;
    localparam logic [2:0] OPC_SUB  = 3'd1;
    localparam logic [2:0] OPC_MUL  = 3'd2;
    localparam logic [2:0] OPC_DIV  = 3'd3;
    localparam logic [2:0] OPC_LPAR = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MALFORMED = 2'd1;
    localparam logic [1:0] ST_DIVZERO   = 2'd2;
    localparam logic [1:0] ST_OVERFLOW  = 2'd3;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Request to the shared divider and its result.
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [39:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
        logic [39:0] remainder;
    } div_rsp_t;

    function automatic logic [1:0] prec(input logic [2:0] op);
        if (op == OPC_ADD || op == OPC_SUB) return 2'd1;
        if (op == OPC_MUL || op == OPC_DIV) return 2'd2;
        return 2'd0;
    endfunction

    function automatic logic [39:0] pow_ten(input logic [3:0] n);
        case (n)
            4'd0:    return 40'd1;
            4'd1:    return 40'd10;
            4'd2:    return 40'd100;
            4'd3:    return 40'd1000;
            4'd4:    return 40'd10000;
            4'd5:    return 40'd100000;
            4'd6:    return 40'd1000000;
            4'd7:    return 40'd10000000;
            default: return 40'd100000000;
        endcase
    endfunction
endpackage
`default_nettype wire

@@ hw/rtl/infix_expression_evaluator.sv @@
// ----------------------------------------------------------------------------
// infix_expression_evaluator
// Shunting-yard evaluator of infix expressions in signed fixed point.
// ----------------------------------------------------------------------------
// One ASCII character is taken per item; the item marked by tlast closes the
// expression and yields one result item with the value and a status. Ending
// a number takes one divider pass for the integer part and then one for the
// fraction, which is skipped if the integer part saturates. Each reduction
// that a character triggers reads the two stacks through their synchronous
// read ports, and a division also takes a divider pass. A result item that
// waits for the sink holds up only the next expression's result.
// The stacks are not cleared after reset.
`default_nettype none
`include "infix_expression_evaluator_macros.svh"
module infix_expression_evaluator #(
    parameter int STACK_DEPTH = iee_pkg::STACK_DEPTH_DEFAULT,
    parameter int FRAC_BITS   = iee_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] ch
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata    // [31:0] value, [33:32] status, zero fill
);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
    localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;
    localparam logic [39:0] IP_MAX = 40'(32'h7FFFFFFF >> FRAC_BITS);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CHAR    = 4'd1;
    localparam logic [3:0] S_NUMDIV  = 4'd2;
    localparam logic [3:0] S_NUMFRAC = 4'd3;
    localparam logic [3:0] S_DISP    = 4'd4;
    localparam logic [3:0] S_OPRD    = 4'd5;
    localparam logic [3:0] S_OPCHK   = 4'd6;
    localparam logic [3:0] S_VRD1    = 4'd7;
    localparam logic [3:0] S_VRD2    = 4'd8;
    localparam logic [3:0] S_ALU     = 4'd9;
    localparam logic [3:0] S_MULW    = 4'd10;
    localparam logic [3:0] S_DIVW    = 4'd11;
    localparam logic [3:0] S_OUT     = 4'd12;

    localparam logic [1:0] M_OP  = 2'd0;
    localparam logic [1:0] M_PAR = 2'd1;
    localparam logic [1:0] M_END = 2'd2;

    logic signed [31:0] vmem [STACK_DEPTH];
    logic [2:0]         omem [STACK_DEPTH];

    logic [3:0]        state_reg, state_next;
    logic [CW-1:0]     vcnt_reg, vcnt_next, ocnt_reg, ocnt_next;
    logic [39:0]       acc_reg, acc_next;
    logic [3:0]        fd_reg, fd_next;
    logic              innum_reg, innum_next, pt_reg, pt_next;
    logic [1:0]        err_reg, err_next;
    logic [7:0]        ch_reg, ch_next;
    logic              last_reg, last_next;
    logic [1:0]        mode_reg, mode_next;
    logic [2:0]        op_reg, op_next;
    logic [2:0]        top_reg, top_next;
    logic signed [31:0] b_reg, b_next;
    logic [39:0]       ip_reg, ip_next;
    logic              neg_reg, neg_next;
    logic signed [63:0] prod_reg, prod_next;
    logic              ovalid_reg, ovalid_next;
    logic [33:0]       odata_reg, odata_next;

    logic              vwe, owe;
    logic [AW-1:0]     vwa, owa, vra, ora;
    logic signed [31:0] vwd, vrd_reg, v0_reg;
    logic [2:0]        owd, ord_reg;

    iee_pkg::div_req_t dreq;
    iee_pkg::div_rsp_t drsp;

    iee_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    logic [3:0]  dig;
    logic [43:0] acc10;
    logic [63:0] qsat_in;
    logic signed [63:0] sum_w, rsig;
    logic [63:0] amag;
    logic [39:0] bmag;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (vwe) vmem[vwa] <= vwd;
        if (owe) omem[owa] <= owd;
        vrd_reg <= vmem[vra];
        ord_reg <= omem[ora];
        v0_reg  <= vmem[0];
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {6'd0, odata_reg};

    always_comb
    begin
        state_next = state_reg; vcnt_next = vcnt_reg; ocnt_next = ocnt_reg;
        acc_next = acc_reg; fd_next = fd_reg; innum_next = innum_reg;
        pt_next = pt_reg; err_next = err_reg; ch_next = ch_reg;
        last_next = last_reg; mode_next = mode_reg; op_next = op_reg;
        top_next = top_reg; b_next = b_reg; ip_next = ip_reg;
        neg_next = neg_reg; prod_next = prod_reg;
        ovalid_next = ovalid_reg; odata_next = odata_reg;
        vwe = 1'b0; owe = 1'b0; vwa = '0; owa = '0; vwd = '0; owd = '0;
        vra = '0; ora = '0;
        dreq = '0;
        dig = ch_reg[3:0] - 4'd0;
        acc10 = {4'd0, acc_reg} * 44'd10 + {40'd0, dig};
        qsat_in = '0; sum_w = '0; rsig = '0; amag = '0; bmag = '0;
        if (ovalid_reg && m_axis_tready) ovalid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    ch_next = s_axis_tdata;
                    last_next = s_axis_tlast;
                    state_next = S_CHAR;
                end
            end
            S_CHAR:
            begin
                if (err_reg != iee_pkg::ST_OK)
                    state_next = last_reg ? S_OUT : S_IDLE;
                else if (ch_reg >= iee_pkg::CH_ZERO && ch_reg <= iee_pkg::CH_NINE)
                begin
                    innum_next = 1'b1;
                    if (!pt_reg)
                        acc_next = acc10[43:40] != 4'd0 ? {40{1'b1}} : acc10[39:0];
                    else if (fd_reg < 4'(iee_pkg::MAX_FRAC_DIGITS) &&
                             acc10[43:40] == 4'd0)
                    begin
                        acc_next = acc10[39:0];
                        fd_next = fd_reg + 4'd1;
                    end
                    state_next = last_reg ? S_NUMDIV : S_IDLE;
                end
                else if (ch_reg == iee_pkg::CH_POINT)
                begin
                    if (pt_reg) err_next = iee_pkg::ST_MALFORMED;
                    else begin innum_next = 1'b1; pt_next = 1'b1; end
                    state_next = last_reg ? S_NUMDIV : S_IDLE;
                end
                else
                    state_next = S_NUMDIV;
            end
            S_NUMDIV:
            begin
                if (err_reg != iee_pkg::ST_OK)
                    state_next = last_reg ? S_OUT : S_IDLE;
                else if (!innum_reg)
                    state_next = S_DISP;
                else
                begin
                    dreq.start = 1'b1;
                    dreq.dividend = {24'd0, acc_reg};
                    dreq.divisor = iee_pkg::pow_ten(fd_reg);
                    state_next = S_NUMFRAC;
                    mode_next = M_OP;
                    ip_next = '0;
                end
            end
            S_NUMFRAC:
            begin
                if (drsp.done)
                begin
                    if (mode_reg == M_OP)
                    begin
                        ip_next = drsp.quotient[39:0];
                        if (drsp.quotient[39:0] > IP_MAX)
                        begin
                            innum_next = 1'b0;
                            mode_next = M_PAR;
                            ip_next = {40{1'b1}};
                        end
                        else
                        begin
                            dreq.start = 1'b1;
                            dreq.dividend = 64'(drsp.remainder) << FRAC_BITS;
                            dreq.divisor = iee_pkg::pow_ten(fd_reg);
                            mode_next = M_PAR;
                        end
                    end
                    else
                        ip_next = drsp.quotient[39:0];
                end
                if (mode_reg == M_PAR && (drsp.done || !innum_reg))
                begin
                    if (!innum_reg)
                        vwd = 32'sh7FFFFFFF;
                    else
                    begin
                        qsat_in = (64'(ip_reg) << FRAC_BITS) + drsp.quotient;
                        vwd = sat32(qsat_in);
                    end
                    innum_next = 1'b0; pt_next = 1'b0; acc_next = '0; fd_next = '0;
                    if (vcnt_reg >= DEPTH_C)
                        err_next = iee_pkg::ST_OVERFLOW;
                    else
                    begin
                        vwe = 1'b1; vwa = vcnt_reg[AW-1:0];
                        vcnt_next = vcnt_reg + 1'b1;
                    end
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                if (err_reg != iee_pkg::ST_OK)
                    state_next = last_reg ? S_OUT : S_IDLE;
                else
                begin
                    state_next = S_OPRD;
                    mode_next = M_OP;
                    case (ch_reg)
                        iee_pkg::CH_SPACE: mode_next = M_END;
                        iee_pkg::CH_LPAR:
                        begin
                            if (ocnt_reg >= DEPTH_C) err_next = iee_pkg::ST_OVERFLOW;
                            else
                            begin
                                owe = 1'b1; owa = ocnt_reg[AW-1:0];
                                owd = iee_pkg::OPC_LPAR;
                                ocnt_next = ocnt_reg + 1'b1;
                            end
                            mode_next = M_END;
                        end
                        iee_pkg::CH_RPAR:   mode_next = M_PAR;
                        iee_pkg::CH_PLUS:   op_next = iee_pkg::OPC_ADD;
                        iee_pkg::CH_MINUS:  op_next = iee_pkg::OPC_SUB;
                        iee_pkg::CH_STAR:   op_next = iee_pkg::OPC_MUL;
                        iee_pkg::CH_SLASH:  op_next = iee_pkg::OPC_DIV;
                        iee_pkg::CH_POINT:  mode_next = M_END;
                        default:
                        begin
                            if (ch_reg >= iee_pkg::CH_ZERO && ch_reg <= iee_pkg::CH_NINE)
                                mode_next = M_END;
                            else
                                err_next = iee_pkg::ST_MALFORMED;
                        end
                    endcase
                    if (mode_next == M_END)
                        state_next = last_reg ? S_OPRD : S_IDLE;
                end
            end
            S_OPRD:
            begin
                if (err_reg != iee_pkg::ST_OK)
                    state_next = last_reg ? S_OUT : S_IDLE;
                else
                begin
                    ora = ocnt_reg[AW-1:0] - 1'b1;
                    state_next = S_OPCHK;
                end
            end
            S_OPCHK:
            begin
                top_next = ord_reg;
                state_next = S_IDLE;
                if (mode_reg == M_OP && !(last_reg && ch_reg == 8'd0 && 1'b0))
                begin
                    if (ocnt_reg != '0 && iee_pkg::prec(ord_reg) >= iee_pkg::prec(op_reg))
                        state_next = S_VRD1;
                    else
                    begin
                        if (ocnt_reg >= DEPTH_C) err_next = iee_pkg::ST_OVERFLOW;
                        else
                        begin
                            owe = 1'b1; owa = ocnt_reg[AW-1:0]; owd = op_reg;
                            ocnt_next = ocnt_reg + 1'b1;
                        end
                        mode_next = M_END;
                        state_next = last_reg ? S_OPRD : S_IDLE;
                    end
                end
                else if (mode_reg == M_PAR)
                begin
                    if (ocnt_reg == '0)
                    begin
                        err_next = iee_pkg::ST_MALFORMED;
                        state_next = last_reg ? S_OUT : S_IDLE;
                    end
                    else if (ord_reg == iee_pkg::OPC_LPAR)
                    begin
                        ocnt_next = ocnt_reg - 1'b1;
                        mode_next = M_END;
                        state_next = last_reg ? S_OPRD : S_IDLE;
                    end
                    else
                        state_next = S_VRD1;
                end
                else
                begin
                    if (ocnt_reg == '0)
                    begin
                        if (vcnt_reg != CW'(1)) err_next = iee_pkg::ST_MALFORMED;
                        state_next = S_OUT;
                    end
                    else if (ord_reg == iee_pkg::OPC_LPAR)
                    begin
                        err_next = iee_pkg::ST_MALFORMED;
                        state_next = S_OUT;
                    end
                    else
                        state_next = S_VRD1;
                end
            end
            S_VRD1:
            begin
                ocnt_next = ocnt_reg - 1'b1;
                if (vcnt_reg < CW'(2))
                begin
                    err_next = iee_pkg::ST_MALFORMED;
                    state_next = last_reg ? S_OUT : S_IDLE;
                end
                else
                begin
                    vra = vcnt_reg[AW-1:0] - 1'b1;
                    state_next = S_VRD2;
                end
            end
            S_VRD2:
            begin
                b_next = vrd_reg;
                vra = vcnt_reg[AW-1:0] - 2'd2;
                state_next = S_ALU;
            end
            S_ALU:
            begin
                vcnt_next = vcnt_reg - CW'(2);
                state_next = S_MULW;
                case (top_reg)
                    iee_pkg::OPC_ADD: prod_next = 64'(vrd_reg) + 64'(b_reg);
                    iee_pkg::OPC_SUB: prod_next = 64'(vrd_reg) - 64'(b_reg);
                    iee_pkg::OPC_MUL: prod_next = 64'(vrd_reg) * 64'(b_reg);
                    iee_pkg::OPC_DIV:
                    begin
                        if (b_reg == 0)
                        begin
                            err_next = iee_pkg::ST_DIVZERO;
                            state_next = last_reg ? S_OUT : S_IDLE;
                        end
                        else
                        begin
                            amag = vrd_reg[31] ? 64'(-64'(vrd_reg)) : 64'(vrd_reg);
                            bmag = b_reg[31] ? 40'(-64'(b_reg)) : 40'(b_reg);
                            neg_next = vrd_reg[31] ^ b_reg[31];
                            dreq.start = 1'b1;
                            dreq.dividend = amag << FRAC_BITS;
                            dreq.divisor = bmag;
                            state_next = S_DIVW;
                        end
                    end
                    default:
                    begin
                        err_next = iee_pkg::ST_MALFORMED;
                        state_next = last_reg ? S_OUT : S_IDLE;
                    end
                endcase
            end
            S_MULW, S_DIVW:
            begin
                if (state_reg == S_MULW || drsp.done)
                begin
                    if (state_reg == S_DIVW)
                        rsig = neg_reg ? -$signed(drsp.quotient) : $signed(drsp.quotient);
                    else if (top_reg == iee_pkg::OPC_MUL)
                        rsig = prod_reg / ONE;
                    else
                        rsig = prod_reg;
                    sum_w = rsig;
                    vwe = 1'b1; vwa = vcnt_reg[AW-1:0]; vwd = sat32(sum_w);
                    vcnt_next = vcnt_reg + 1'b1;
                    state_next = S_OPRD;
                end
            end
            S_OUT:
            begin
                if (!ovalid_reg || m_axis_tready)
                begin
                    ovalid_next = 1'b1;
                    odata_next = {err_reg, (err_reg == iee_pkg::ST_OK) ? v0_reg : 32'sd0};
                    vcnt_next = '0; ocnt_next = '0; acc_next = '0; fd_next = '0;
                    innum_next = 1'b0; pt_next = 1'b0; err_next = iee_pkg::ST_OK;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE; vcnt_reg <= '0; ocnt_reg <= '0; acc_reg <= '0;
            fd_reg <= '0; innum_reg <= 1'b0; pt_reg <= 1'b0; err_reg <= '0;
            ovalid_reg <= 1'b0; mode_reg <= M_OP;
        end
        else
        begin
            state_reg <= state_next; vcnt_reg <= vcnt_next; ocnt_reg <= ocnt_next;
            acc_reg <= acc_next; fd_reg <= fd_next; innum_reg <= innum_next;
            pt_reg <= pt_next; err_reg <= err_next; ovalid_reg <= ovalid_next;
            mode_reg <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg <= ch_next; last_reg <= last_next; op_reg <= op_next;
        top_reg <= top_next; b_reg <= b_next; ip_reg <= ip_next;
        neg_reg <= neg_next; prod_reg <= prod_next; odata_reg <= odata_next;
    end

    `IEE_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, vcnt_reg <= DEPTH_C && ocnt_reg <= DEPTH_C,
        "stack count beyond depth")
    `IEE_ASSERT_NEXT(a_out_hold, clk, rst_n, ovalid_reg && !m_axis_tready,
        ovalid_reg && $stable(odata_reg), "result dropped while stalled")
    `IEE_ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_reg != S_IDLE, !s_axis_tready,
        "item taken while busy")
    `IEE_ASSERT_IMP(a_err_out_zero, clk, rst_n, ovalid_reg && odata_reg[33:32] != 2'd0,
        odata_reg[31:0] == 32'd0, "error result carries a value")
endmodule
`default_nettype wire

@@ hw/rtl/iee_divider.sv @@
// ----------------------------------------------------------------------------
// iee_divider
// Unsigned restoring divider, 64 by 40 bits, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module iee_divider (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire iee_pkg::div_req_t req,
    output iee_pkg::div_rsp_t     rsp
);
    logic [63:0] quo_reg, quo_next;
    logic [40:0] rem_reg, rem_next;
    logic [39:0] dsr_reg, dsr_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [41:0] trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = '0;
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial = {rem_reg, quo_reg[63]} - {2'b00, dsr_reg};
            if (!trial[41])
            begin
                rem_next = trial[40:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[39:0], quo_reg[63]};
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg[39:0];
endmodule
`default_nettype wire

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Streams infix expressions and random character strings into the evaluator
// one character per item, with random idling on both sides, and checks each
// value and status against a shunting-yard predictor kept in the scoreboard.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class expr_scoreboard;
    int signed  vals [16];
    logic [2:0] ops [16];
    int         nv;
    int         nop;
    longint unsigned mant;
    int         fdig;
    bit         in_num;
    bit         pnt;
    logic [1:0] err;
    logic [33:0] pending [$];
    int         fails;

    function void clear();
        nv = 0;
        nop = 0;
        mant = 0;
        fdig = 0;
        in_num = 0;
        pnt = 0;
        err = iee_pkg::ST_OK;
    endfunction

    function void flag(logic [1:0] c);
        if (err == iee_pkg::ST_OK)
            err = c;
    endfunction

    function int signed clip(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return int'(v);
    endfunction

    function void push_val(int signed v);
        if (nv >= 16)
        begin
            flag(iee_pkg::ST_OVERFLOW);
            return;
        end
        vals[nv] = v;
        nv++;
    endfunction

    function void push_op(logic [2:0] o);
        if (nop >= 16)
        begin
            flag(iee_pkg::ST_OVERFLOW);
            return;
        end
        ops[nop] = o;
        nop++;
    endfunction

    function int rank(logic [2:0] o);
        if (o == iee_pkg::OPC_ADD || o == iee_pkg::OPC_SUB) return 1;
        if (o == iee_pkg::OPC_MUL || o == iee_pkg::OPC_DIV) return 2;
        return 0;
    endfunction

    function void apply_top();
        logic [2:0] o;
        longint a;
        longint b;
        longint r;
        if (nop == 0)
        begin
            flag(iee_pkg::ST_MALFORMED);
            return;
        end
        nop--;
        o = ops[nop];
        if (nv < 2)
        begin
            flag(iee_pkg::ST_MALFORMED);
            return;
        end
        nv--;
        b = vals[nv];
        nv--;
        a = vals[nv];
        case (o)
            iee_pkg::OPC_ADD: r = a + b;
            iee_pkg::OPC_SUB: r = a - b;
            iee_pkg::OPC_MUL: r = (a * b) / 65536;
            iee_pkg::OPC_DIV:
            begin
                if (b == 0)
                begin
                    flag(iee_pkg::ST_DIVZERO);
                    return;
                end
                r = (a * 65536) / b;
            end
            default:
            begin
                flag(iee_pkg::ST_MALFORMED);
                return;
            end
        endcase
        push_val(clip(r));
    endfunction

    function void close_number();
        longint unsigned p;
        longint unsigned ip;
        longint unsigned rm;
        longint unsigned v;
        if (!in_num) return;
        p = 1;
        for (int i = 0; i < fdig && i < 8; i++) p = p * 10;
        ip = mant / p;
        rm = mant % p;
        if (ip > 32767)
            v = 64'h7fffffff;
        else
            v = (ip << 16) + ((rm << 16) / p);
        if (v > 64'h7fffffff) v = 64'h7fffffff;
        in_num = 0;
        pnt = 0;
        mant = 0;
        fdig = 0;
        push_val(int'(v));
    endfunction

    function void take(logic [7:0] c);
        longint unsigned d;
        longint unsigned amax;
        logic [2:0] o;
        amax = (64'd1 << 40) - 1;
        if (c >= iee_pkg::CH_ZERO && c <= iee_pkg::CH_NINE)
        begin
            d = c - iee_pkg::CH_ZERO;
            in_num = 1;
            if (!pnt)
                mant = (mant > (amax - d) / 10) ? amax : mant * 10 + d;
            else if (fdig < 8 && mant <= (amax - d) / 10)
            begin
                mant = mant * 10 + d;
                fdig++;
            end
            return;
        end
        if (c == iee_pkg::CH_POINT)
        begin
            if (pnt)
            begin
                flag(iee_pkg::ST_MALFORMED);
                return;
            end
            in_num = 1;
            pnt = 1;
            return;
        end
        close_number();
        if (err != iee_pkg::ST_OK) return;
        case (c)
            iee_pkg::CH_SPACE: return;
            iee_pkg::CH_LPAR:
            begin
                push_op(iee_pkg::OPC_LPAR);
                return;
            end
            iee_pkg::CH_RPAR:
            begin
                while (err == iee_pkg::ST_OK && nop > 0 && ops[nop-1] != iee_pkg::OPC_LPAR)
                    apply_top();
                if (err != iee_pkg::ST_OK) return;
                if (nop == 0)
                begin
                    flag(iee_pkg::ST_MALFORMED);
                    return;
                end
                nop--;
                return;
            end
            iee_pkg::CH_PLUS: o = iee_pkg::OPC_ADD;
            iee_pkg::CH_MINUS: o = iee_pkg::OPC_SUB;
            iee_pkg::CH_STAR: o = iee_pkg::OPC_MUL;
            iee_pkg::CH_SLASH: o = iee_pkg::OPC_DIV;
            default:
            begin
                flag(iee_pkg::ST_MALFORMED);
                return;
            end
        endcase
        while (err == iee_pkg::ST_OK && nop > 0 && rank(ops[nop-1]) >= rank(o))
            apply_top();
        if (err == iee_pkg::ST_OK)
            push_op(o);
    endfunction

    function void note_char(logic [7:0] c, bit lst);
        int signed v;
        v = 0;
        if (err == iee_pkg::ST_OK) take(c);
        if (!lst) return;
        if (err == iee_pkg::ST_OK) close_number();
        while (err == iee_pkg::ST_OK && nop > 0)
        begin
            if (ops[nop-1] == iee_pkg::OPC_LPAR)
                flag(iee_pkg::ST_MALFORMED);
            else
                apply_top();
        end
        if (err == iee_pkg::ST_OK && nv != 1) flag(iee_pkg::ST_MALFORMED);
        if (err == iee_pkg::ST_OK) v = vals[0];
        pending.push_back({err, v});
        clear();
    endfunction

    function void check_result(logic [39:0] d);
        logic [33:0] e;
        if (pending.size() == 0)
        begin
            $error("result item with no expression pending: %h", d);
            fails++;
            return;
        end
        e = pending.pop_front();
        if (d[31:0] !== e[31:0])
        begin
            $error("value: expected %h, actual %h", e[31:0], d[31:0]);
            fails++;
        end
        if (d[33:32] !== e[33:32])
        begin
            $error("status: expected %0d, actual %0d", e[33:32], d[33:32]);
            fails++;
        end
    endfunction
endclass

module tb_top;
    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;

    expr_scoreboard sb;
    int  idle_pct;
    longint cycles;
    int  sent;

    infix_expression_evaluator u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        sb = new();
        sb.clear();
        sb.fails = 0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 20000000)
        begin
            $display("tb_top failed");
            $finish;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= idle_pct);

    function automatic string ch_str(logic [7:0] c);
        string t;
        t = " ";
        t[0] = c;
        return t;
    endfunction

    task automatic send_char(logic [7:0] c, bit lst);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= c;
        s_axis_tlast <= lst;
        while (!s_axis_tready) @(negedge clk);
        @(posedge clk);
        sb.note_char(c, lst);
        sent++;
        @(negedge clk);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    function automatic string rand_num();
        string s;
        int n;
        s = "";
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) s = {s, ch_str(8'(8'h30 + $urandom_range(9)))};
        if ($urandom_range(2) == 0)
        begin
            s = {s, "."};
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++) s = {s, ch_str(8'(8'h30 + $urandom_range(9)))};
        end
        return s;
    endfunction

    function automatic string rand_expr(int depth);
        string s;
        string opset;
        int n;
        opset = "+-*/";
        n = $urandom_range(1, 3);
        s = "";
        for (int i = 0; i < n; i++)
        begin
            if (i > 0)
            begin
                s = {s, ch_str(opset[$urandom_range(3)])};
                if ($urandom_range(3) == 0) s = {s, " "};
            end
            if (depth > 0 && $urandom_range(3) == 0)
                s = {s, "(", rand_expr(depth - 1), ")"};
            else
                s = {s, rand_num()};
        end
        return s;
    endfunction

    task automatic drain();
        s_axis_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        string pool;
        sent = 0;
        idle_pct = 26;
        pool = "0123456789+-*/(). ";
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = 0;
        s_axis_tlast = 0;
        m_axis_tready = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        send_text("1+2*3");
        send_text("(1-2)/4");
        send_text("1/0");
        send_text("1/(2-2)");
        send_text("32767.99999999+32767*9");
        send_text("99999999999999");
        send_text("1.2.3");
        send_text("2 x 3");
        send_text("-1");
        send_text("(1+2");
        send_text("1+2)");
        send_text(".");
        send_text("1+2 ");
        send_text("((((((((((((((((((1))))))))))))))))))");
        send_text("1+1+1+1+1+1+1+1*(1*(1*(1*(1*(1*(1*(1*(1*(1*(1+1))))))))))");
        send_char(8'hff, 1);
        send_char(8'h00, 1);
        send_char(iee_pkg::CH_SPACE, 1);
        drain();

        while (sent < 1200)
        begin
            if (sent > 400 && sent < 700) idle_pct = 0;
            else idle_pct = 26;
            if ($urandom_range(9) < 8)
                send_text(rand_expr(3));
            else
            begin
                int n;
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++)
                    send_char($urandom_range(9) < 4 ? 8'($urandom) :
                              8'(pool[$urandom_range(17)]),
                              i == n - 1);
            end
            if ($urandom_range(49) == 0) drain();
        end
        drain();
        if (sb.fails == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule
